// ===== design/sglr_pkg.sv =====
// ----------------------------------------------------------------------------
// sglr_pkg
// Shared types, constants and Q16.16 helpers for the SGD regression trainer.
// ----------------------------------------------------------------------------
`default_nettype none
package sglr_pkg;

  localparam int MaxFeatures = 16;
  localparam int NumCells    = MaxFeatures + 1;
  localparam int CntW        = $clog2(MaxFeatures + 1);
  localparam int IdxW        = $clog2(NumCells + 1);
  localparam logic [16:0] OneQ16 = 17'd65536;

  localparam logic [2:0] CfgLr   = 3'd0;
  localparam logic [2:0] CfgLam  = 3'd1;
  localparam logic [2:0] CfgMix  = 3'd2;
  localparam logic [2:0] CfgMode = 3'd3;
  localparam logic [2:0] CfgCnt  = 3'd4;

  localparam logic [1:0] RegNone = 2'd0;
  localparam logic [1:0] RegL2   = 2'd1;
  localparam logic [1:0] RegL1   = 2'd2;
  localparam logic [1:0] RegEn   = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ALIGN, ST_DOT, ST_GRAD, ST_REG, ST_STEP, ST_FLAG, ST_OUT
  } state_t;

  typedef struct packed {
    logic               clear;
    logic               shift;
    logic               dot;
    logic [2:0]         upd;
    logic signed [31:0] err;
    logic [16:0]        lr;
    logic [30:0]        lam;
    logic [16:0]        mix;
    logic [1:0]         mode;
  } cell_ctl_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v,
                                               output logic f);
    f = 1'b0;
    if (v > 66'sd2147483647) begin
      f = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -66'sd2147483648) begin
      f = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [47:0] mulq(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] p;
    p = a * b;
    return p[63:16];
  endfunction

endpackage
`default_nettype wire

// ===== design/sglr_cell.sv =====
// ----------------------------------------------------------------------------
// sglr_cell
// One weight cell: holds a weight and a feature, adds its dot term to the
// passing partial sum and applies its own SGD update in three steps.
// ----------------------------------------------------------------------------
`default_nettype none
module sglr_cell import sglr_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cell_ctl_t          ctl,
  input  wire logic               is_bias,
  input  wire logic               active,
  input  wire logic signed [31:0] x_in,
  output logic signed [31:0]      x_out,
  input  wire logic signed [65:0] sum_in,
  output logic signed [65:0]      sum_out,
  output logic                    sat_out
);
  logic signed [31:0] w_r, w_nxt, x_r;
  logic signed [31:0] gx_r, rt_r, g_r;
  logic signed [31:0] xv, gx, rt0, inn, rt, gs, stp, lam_s, lr_s, am;
  logic signed [65:0] sum_r;
  logic               sat_r, f0, f1, f2, f3, f4, f5, f6;
  logic signed [33:0] s;

  assign x_out   = x_r;
  assign sum_out = sum_r;
  assign sat_out = sat_r;
  assign xv      = is_bias ? 32'sh00010000 : x_r;
  assign am      = {15'd0, ctl.mix};
  assign lam_s   = {1'b0, ctl.lam};
  assign lr_s    = {15'd0, ctl.lr};

  always_comb begin
    f1 = 1'b0; f2 = 1'b0; f3 = 1'b0;
    s   = (w_r > 0) ? 34'sd1 : -34'sd1;
    gx  = sat32(66'(2 * mulq(ctl.err, xv)), f0);
    rt0 = '0;
    inn = '0;
    unique case (ctl.mode)
      RegL2: rt0 = sat32(66'(2 * mulq(lam_s, w_r)), f1);
      RegL1: rt0 = sat32(66'(s * lam_s), f1);
      RegEn: begin
        inn = sat32(66'(2 * mulq(32'sh00010000 - am, w_r)), f1);
        rt0 = sat32(66'(s * am) + 66'(inn), f2);
      end
      default: rt0 = '0;
    endcase
    rt = rt_r;
    if (ctl.mode == RegEn) rt = sat32(66'(mulq(lam_s, rt_r)), f3);
    gs    = sat32(66'(gx_r) + 66'(rt), f4);
    stp   = sat32(66'(mulq(lr_s, g_r)), f5);
    w_nxt = sat32(66'(w_r) - 66'(stp), f6);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r <= '0;
      sat_r <= 1'b0;
    end else if (ctl.clear) begin
      w_r <= '0;
    end else if (ctl.upd[0]) begin
      sat_r <= active & (f0 | (~is_bias & (f1 | f2)));
    end else if (ctl.upd[1]) begin
      sat_r <= sat_r | (active & ~is_bias & (f3 | f4));
    end else if (ctl.upd[2]) begin
      sat_r <= sat_r | (active & (f5 | f6));
      if (active) w_r <= w_nxt;
    end
    if (ctl.upd[0]) begin
      gx_r <= gx;
      rt_r <= rt0;
    end
    if (ctl.upd[1]) g_r <= is_bias ? gx_r : gs;
    if (ctl.shift) x_r <= x_in;
    if (ctl.dot) begin
      if (is_bias) sum_r <= sum_in + 66'(w_r);
      else if (active) sum_r <= sum_in + 66'(mulq(w_r, x_r));
      else sum_r <= sum_in;
    end
  end
endmodule
`default_nettype wire

// ===== design/sgd_linear_regression_trainer_unit.sv =====
// Sequence: the sample's last beat starts the align shifts (skipped when all
// 16 features are in use), the dot states as the sum ripples down the row,
// the update states GRAD, REG and STEP, a flag state and the output state.
// Throughput: one feature beat per cycle, only while idle (in_stall low).
// Synchronous active-low reset: weights zero, registers to defaults.
// ----------------------------------------------------------------------------
// sgd_linear_regression_trainer_unit
// Top level: feature shift row of cells, control sequencer, output register.
// ----------------------------------------------------------------------------
`default_nettype none
module sgd_linear_regression_trainer_unit import sglr_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [30:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_cmd,
  input  wire logic signed [31:0] in_feature_value,
  input  wire logic signed [31:0] in_target,
  input  wire logic               in_train,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      out_prediction,
  output logic signed [31:0]      out_residual,
  output logic                    out_saturated
);
  logic [16:0] lr_r, mix_r;
  logic [30:0] lam_r;
  logic [1:0]  mode_r;
  logic [4:0]  fc_r;
  logic [CntW-1:0] cnt_r, cnt_nxt, use_cnt;
  logic [IdxW-1:0] step_r, step_nxt, align_last;
  state_t st_r, st_nxt;
  logic signed [31:0] tgt_r, pred_r, pred_nxt, err_r, err_nxt;
  logic train_r, flag_r, flag_nxt, fp, fe;
  logic signed [31:0] xs [NumCells+1];
  logic signed [65:0] ss [NumCells+1];
  logic [NumCells-1:0] sats;
  cell_ctl_t ctl;
  logic acc, beat;

  always_comb begin
    if (fc_r == 5'd0) use_cnt = CntW'(1);
    else if (fc_r > 5'(MaxFeatures)) use_cnt = CntW'(MaxFeatures);
    else use_cnt = CntW'(fc_r);
  end

  assign in_stall   = (st_r != ST_IDLE);
  assign acc        = in_valid & ~in_stall;
  assign beat       = acc & ~in_cmd;
  assign align_last = IdxW'(MaxFeatures - 1) - IdxW'(use_cnt);
  assign xs[0] = in_feature_value;
  assign ss[0] = '0;

  always_comb begin
    ctl.clear = acc & in_cmd;
    ctl.shift = beat | (st_r == ST_ALIGN);
    ctl.dot   = (st_r == ST_DOT);
    ctl.upd   = {(st_r == ST_STEP), (st_r == ST_REG), (st_r == ST_GRAD)} & {3{train_r}};
    ctl.err   = err_r;
    ctl.lr    = (lr_r > OneQ16) ? OneQ16 : lr_r;
    ctl.lam   = lam_r;
    ctl.mix   = (mix_r > OneQ16) ? OneQ16 : mix_r;
    ctl.mode  = mode_r;
  end

  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    // after alignment cell i holds feature MaxFeatures-1-i; bias last
    logic bias, act;
    assign bias = (i == NumCells - 1);
    assign act  = bias | (i >= MaxFeatures - int'(use_cnt));
    sglr_cell u_cell (
      .clk, .rst_n, .ctl, .is_bias(bias), .active(act),
      .x_in(xs[i]), .x_out(xs[i+1]), .sum_in(ss[i]), .sum_out(ss[i+1]),
      .sat_out(sats[i])
    );
  end

  always_comb begin
    st_nxt = st_r; cnt_nxt = cnt_r; step_nxt = step_r;
    pred_nxt = pred_r; err_nxt = err_r; flag_nxt = flag_r;
    fp = 1'b0; fe = 1'b0;
    unique case (st_r)
      ST_IDLE: if (beat) begin
        if (cnt_r + 1'b1 >= use_cnt) begin
          cnt_nxt = '0; step_nxt = '0;
          st_nxt = (use_cnt == CntW'(MaxFeatures)) ? ST_DOT : ST_ALIGN;
        end else cnt_nxt = cnt_r + 1'b1;
      end
      ST_ALIGN: begin
        step_nxt = step_r + 1'b1;
        if (step_r == align_last) begin
          st_nxt = ST_DOT;
          step_nxt = '0;
        end
      end
      ST_DOT: begin
        step_nxt = step_r + 1'b1;
        if (step_r == IdxW'(NumCells)) st_nxt = ST_GRAD;
      end
      ST_GRAD: st_nxt = ST_REG;
      ST_REG:  st_nxt = ST_STEP;
      ST_STEP: st_nxt = ST_FLAG;
      ST_FLAG: begin
        flag_nxt = flag_r | (train_r & (|sats));
        st_nxt = ST_OUT;
      end
      ST_OUT: if (!out_valid || !out_stall) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
    if (st_r == ST_DOT && step_r == IdxW'(NumCells)) begin
      pred_nxt = sat32(ss[NumCells], fp);
      err_nxt  = train_r ? sat32(66'(pred_nxt) - 66'(tgt_r), fe) : '0;
      flag_nxt = fp | (train_r & fe);
    end
    if (cfg_we && cfg_index == CfgCnt) cnt_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; cnt_r <= '0; step_r <= '0; out_valid <= 1'b0;
      lr_r <= 17'd655; lam_r <= '0; mix_r <= 17'd32768; mode_r <= RegNone;
      fc_r <= 5'd1;
    end else begin
      st_r <= st_nxt; cnt_r <= cnt_nxt; step_r <= step_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CfgLr:   lr_r <= cfg_data[16:0];
          CfgLam:  lam_r <= cfg_data;
          CfgMix:  mix_r <= cfg_data[16:0];
          CfgMode: mode_r <= cfg_data[1:0];
          CfgCnt:  fc_r <= cfg_data[4:0];
          default: ;
        endcase
      end
      out_valid <= (st_r == ST_OUT && (!out_valid || !out_stall)) ||
                   (out_valid && out_stall);
    end
    pred_r <= pred_nxt; err_r <= err_nxt; flag_r <= flag_nxt;
    if (beat) begin
      tgt_r <= in_target;
      train_r <= in_train;
    end
    if (st_r == ST_OUT && (!out_valid || !out_stall)) begin
      out_prediction <= pred_r;
      out_residual <= err_r;
      out_saturated <= flag_r;
    end
  end
endmodule
`default_nettype wire

// ===== design/sglr_checker.sv =====
// ----------------------------------------------------------------------------
// sglr_checker
// Port-level checks for the trainer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module sglr_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] out_residual
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_residual)) else $error("out beat lost");
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall) else $error("not idle after reset");
  a_busy_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall)) else $error("beat without work");
endmodule

bind sgd_linear_regression_trainer_unit sglr_checker u_chk (
  .clk, .rst_n, .in_stall, .out_valid, .out_stall, .out_residual
);
`default_nettype wire

// ===== tb/sv/sglr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sglr_scoreboard
// Watches the config port and both channels of the SGD regression trainer,
// keeps its own Q16.16 copy of weights and sample buffer, predicts every
// sample result and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module sglr_scoreboard import sglr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [30:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               in_cmd,
  input  logic signed [31:0] in_feature_value,
  input  logic signed [31:0] in_target,
  input  logic               in_train,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] out_prediction,
  input  logic signed [31:0] out_residual,
  input  logic               out_saturated,
  output int                 fail_count,
  output int                 pending,
  output int                 samples_done
);

  typedef struct {
    logic signed [31:0] pred;
    logic signed [31:0] resid;
    logic               sat;
  } sample_result_t;

  sample_result_t result_queue[$];

  logic [16:0] lr_q;
  logic [30:0] lam_q;
  logic [16:0] mix_q;
  logic [1:0]  mode_q;
  logic [4:0]  cnt_q;
  logic signed [31:0] wts[NumCells];
  logic signed [31:0] feats[MaxFeatures];
  int fill;

  function automatic longint q_mul(longint a, longint b);
    longint p;
    p = a * b;
    return p >>> 16;
  endfunction

  function automatic longint clamp32(longint v, inout logic f);
    if (v > 64'sd2147483647) begin
      f = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      f = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint penalty(longint w, inout logic f);
    longint lam, s, a, inner;
    lam = lam_q;
    s = (w > 0) ? 1 : -1;
    a = (mix_q > OneQ16) ? 65536 : mix_q;
    case (mode_q)
      RegL2: return clamp32(2 * q_mul(lam, w), f);
      RegL1: return clamp32(s * lam, f);
      RegEn: begin
        inner = clamp32(2 * q_mul(65536 - a, w), f);
        inner = clamp32(s * a + inner, f);
        return clamp32(q_mul(lam, inner), f);
      end
      default: return 0;
    endcase
  endfunction

  task automatic take_feature(logic signed [31:0] xv, logic signed [31:0] tgt, logic trn);
    int n;
    logic f;
    longint acc, pred, err, lr, w, x, g, stp, rt;
    sample_result_t r;
    n = cnt_q;
    if (n < 1) n = 1;
    if (n > MaxFeatures) n = MaxFeatures;
    f = 1'b0;
    err = 0;
    if (fill >= MaxFeatures) fill = 0;
    feats[fill] = xv;
    fill++;
    if (fill < n) return;
    fill = 0;
    acc = wts[0];
    for (int j = 0; j < n; j++) acc += q_mul(wts[j+1], feats[j]);
    pred = clamp32(acc, f);
    if (trn) begin
      lr = (lr_q > OneQ16) ? 65536 : lr_q;
      err = clamp32(pred - longint'(tgt), f);
      for (int j = 0; j <= n; j++) begin
        w = wts[j];
        x = (j == 0) ? 65536 : longint'(feats[j-1]);
        g = clamp32(2 * q_mul(err, x), f);
        if (j > 0) begin
          rt = penalty(w, f);
          g = clamp32(g + rt, f);
        end
        stp = clamp32(q_mul(lr, g), f);
        wts[j] = 32'(clamp32(w - stp, f));
      end
    end
    r.pred = 32'(pred);
    r.resid = 32'(err);
    r.sat = f;
    result_queue.insert(result_queue.size(), r);
  endtask

  always @(posedge clk) begin
    sample_result_t e;
    if (!rst_n) begin
      lr_q <= 17'd655;
      lam_q <= '0;
      mix_q <= 17'd32768;
      mode_q <= RegNone;
      cnt_q <= 5'd1;
      for (int i = 0; i < NumCells; i++) wts[i] = '0;
      for (int i = 0; i < MaxFeatures; i++) feats[i] = '0;
      fill = 0;
      result_queue.delete();
      fail_count <= 0;
      samples_done <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CfgLr:   lr_q <= cfg_data[16:0];
          CfgLam:  lam_q <= cfg_data;
          CfgMix:  mix_q <= cfg_data[16:0];
          CfgMode: mode_q <= cfg_data[1:0];
          CfgCnt: begin
            cnt_q <= cfg_data[4:0];
            fill = 0;
          end
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (in_cmd) begin
          for (int i = 0; i < NumCells; i++) wts[i] = '0;
        end else begin
          take_feature(in_feature_value, in_target, in_train);
        end
      end
      if (out_valid && !out_stall) begin
        samples_done <= samples_done + 1;
        if (result_queue.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected result beat pred=%0d", out_prediction);
        end else begin
          e = result_queue.pop_front();
          if (e.pred !== out_prediction || e.resid !== out_residual ||
              e.sat !== out_saturated) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("mismatch: exp pred=%0d res=%0d sat=%0b got pred=%0d res=%0d sat=%0b",
                       e.pred, e.resid, e.sat, out_prediction, out_residual, out_saturated);
          end
        end
      end
    end
    pending = result_queue.size();
  end

endmodule

// ===== tb/sv/tb_sgd_linear_regression_trainer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sgd_linear_regression_trainer_unit
// Drives config phases, directed and random feature beats with random gaps
// and output stalls; the scoreboard predicts and compares every sample result.
// ----------------------------------------------------------------------------
module tb_sgd_linear_regression_trainer_unit;
  import sglr_pkg::*;

  logic clk, rst_n;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [30:0] cfg_data;
  logic in_valid, in_stall, in_cmd, in_train;
  logic signed [31:0] in_feature_value, in_target;
  logic out_valid, out_stall, out_saturated;
  logic signed [31:0] out_prediction, out_residual;
  int fail_count, pending, samples_done;
  int beats_sent;
  int cur_count;

  sgd_linear_regression_trainer_unit dut (.*);

  sglr_scoreboard chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] rand_word(int mode);
    case (mode)
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return $signed($urandom_range(0, 8 * 65536)) - 4 * 65536;
    endcase
  endfunction

  initial begin
    int n;
    out_stall = 1'b0;
    @(posedge clk);
    forever begin
      out_stall <= ($urandom_range(0, 99) < 25);
      n = ($urandom_range(0, 99) < 3) ? $urandom_range(10, 30) : 1;
      repeat (n) @(posedge clk);
    end
  end

  task automatic send_beat(logic cmd, logic [31:0] xv, logic [31:0] tgt, logic trn);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_feature_value <= xv;
    in_target <= tgt;
    in_train <= trn;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (NumCells + 10) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [30:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CfgCnt) begin
      cur_count = val[4:0];
      if (cur_count < 1) cur_count = 1;
      if (cur_count > MaxFeatures) cur_count = MaxFeatures;
    end
  endtask

  task automatic run_samples(int n, int mode);
    for (int s = 0; s < n; s++) begin
      if ($urandom_range(0, 49) == 0) send_beat(1'b1, rand_word(0), rand_word(0), 1'($urandom));
      for (int k = 0; k < cur_count; k++)
        send_beat(1'b0, rand_word(($urandom_range(0, 19) == 0) ? 1 : mode),
                  rand_word(($urandom_range(0, 19) == 0) ? 1 : mode),
                  $urandom_range(0, 9) != 0);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CfgLr;
    cfg_data = '0;
    in_valid = 1'b0;
    in_cmd = 1'b0;
    in_feature_value = '0;
    in_target = '0;
    in_train = 1'b0;
    beats_sent = 0;
    cur_count = 1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_beat(1'b0, 32'h00010000, 32'h00020000, 1'b1);
    send_beat(1'b0, 32'h7fffffff, 32'h80000000, 1'b1);
    send_beat(1'b0, 32'h80000000, 32'h7fffffff, 1'b1);
    send_beat(1'b0, 32'h00000000, 32'h00000000, 1'b0);
    send_beat(1'b1, 32'hffffffff, 32'hffffffff, 1'b1);
    send_beat(1'b0, 32'hffff0000, 32'h00010000, 1'b1);
    drain();
    write_reg(CfgCnt, 31'd0);
    write_reg(CfgLr, 31'h1ffff);
    write_reg(CfgMode, {29'd0, RegL2});
    write_reg(CfgLam, 31'h7fffffff);
    send_beat(1'b0, 32'h00008000, 32'h00030000, 1'b1);
    send_beat(1'b0, 32'h00008000, 32'h00030000, 1'b1);
    drain();
    write_reg(CfgCnt, 31'd31);
    write_reg(CfgMode, {29'd0, RegEn});
    write_reg(CfgMix, 31'h1ffff);
    write_reg(CfgLam, 31'd6554);
    write_reg(CfgLr, 31'd0);
    send_beat(1'b0, 32'h00010000, 32'h0, 1'b1);
    send_beat(1'b0, 32'h00020000, 32'h0, 1'b1);
    drain();
    write_reg(CfgCnt, 31'd16);
    run_samples(1, 2);
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      write_reg(CfgCnt, (ph % 4 == 3) ? 31'd16 : 31'($urandom_range(0, 6)));
      write_reg(CfgLr, (ph % 3 == 0) ? 31'($urandom_range(0, 1) ? 0 : 65536)
                                     : 31'($urandom_range(0, 4000)));
      write_reg(CfgLam, (ph == 5) ? 31'h7fffffff : 31'($urandom_range(0, 20000)));
      write_reg(CfgMix, (ph % 4 == 1) ? 31'd0 : 31'($urandom_range(0, 65536)));
      write_reg(CfgMode, 31'(ph % 4));
      while (beats_sent < 150 * (ph + 1) + 20) run_samples(1, (ph % 3 == 2) ? 0 : 2);
      if (ph % 2 == 1) begin
        drain();
        if (cur_count > 1) begin
          send_beat(1'b0, rand_word(2), rand_word(2), 1'b1);
          in_valid <= 1'b0;
          @(posedge clk);
        end
        write_reg(CfgCnt, 31'(cur_count));
        run_samples(1, 2);
      end
      drain();
    end

    $display("Sent %0d beats; %0d sample results checked across 12 config phases.",
             beats_sent, samples_done);
    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
design/sglr_pkg.sv
design/sglr_cell.sv
design/sgd_linear_regression_trainer_unit.sv
design/sglr_checker.sv
tb/sv/sglr_checker.sv
tb/sv/tb_sgd_linear_regression_trainer_unit.sv
